// File: rtl/ptw_pkg.sv
package ptw_pkg;

  localparam int ADDR_W = 52;
  localparam int VA_W   = 48;
  localparam int PAB_W  = 6;
  localparam int LOW_W  = 30;

  // Depths of the command queue (front to back) and of the result queue.
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [PAB_W-1:0] PAB_RESET = 6'd36;
  localparam logic [PAB_W-1:0] PAB_MAX   = 6'd52;

  localparam int PAGE_SIZE_BIT = 7;

  // Input opcodes.
  localparam logic OPC_START = 1'b0;
  localparam logic OPC_ENTRY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_TABLE_BASE = 1'b0;
  localparam logic REG_PHYS_BITS  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  // Page sizes.
  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  // Walk levels: which entry the walk waits for.
  localparam logic [1:0] LVL_L4 = 2'd0;
  localparam logic [1:0] LVL_L3 = 2'd1;
  localparam logic [1:0] LVL_L2 = 2'd2;
  localparam logic [1:0] LVL_L1 = 2'd3;

  typedef enum logic [2:0] {
    OP_READ,
    OP_DONE_4K,
    OP_DONE_2M,
    OP_DONE_1G,
    OP_IGNORE
  } op_t;

  // Command from the front to the back: base or entry, and the low part to add.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] base;
    logic [LOW_W-1:0]  low;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [1:0]        page_size;
  } res_t;

endpackage

// File: rtl/ptw_fifo.sv
module ptw_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a write");

endmodule

// File: rtl/ptw_front.sv
module ptw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        opcode,
  input  logic [ptw_pkg::VA_W-1:0]    virt_addr,
  input  logic [63:0]                 entry_data,
  input  logic [ptw_pkg::ADDR_W-1:0]  table_base,
  output ptw_pkg::cmd_t               cmd
);

  logic                     busy_r, busy_nxt;
  logic [1:0]               level_r, level_nxt;
  logic [ptw_pkg::VA_W-1:0] va_r, va_nxt;
  logic [8:0]               next_slot;
  logic                     big;

  assign big = entry_data[ptw_pkg::PAGE_SIZE_BIT];

  // Table slot of the level below the one whose entry just came back.
  always_comb begin
    case (level_r)
      ptw_pkg::LVL_L4: next_slot = va_r[38:30];
      ptw_pkg::LVL_L3: next_slot = va_r[29:21];
      default:         next_slot = va_r[20:12];
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    level_nxt = level_r;
    va_nxt    = va_r;
    cmd.op    = ptw_pkg::OP_IGNORE;
    cmd.base  = '0;
    cmd.low   = '0;
    if (accept) begin
      if (opcode == ptw_pkg::OPC_START) begin
        // A start always restarts the walk, dropping any walk in progress.
        busy_nxt  = 1'b1;
        level_nxt = ptw_pkg::LVL_L4;
        va_nxt    = virt_addr;
        cmd.op    = ptw_pkg::OP_READ;
        cmd.base  = table_base;
        cmd.low   = {18'b0, virt_addr[47:39], 3'b0};
      end else if (!busy_r) begin
        cmd.op = ptw_pkg::OP_IGNORE;
      end else if (level_r == ptw_pkg::LVL_L3 && big) begin
        busy_nxt  = 1'b0;
        level_nxt = ptw_pkg::LVL_L4;
        cmd.op    = ptw_pkg::OP_DONE_1G;
        cmd.base  = entry_data[ptw_pkg::ADDR_W-1:0];
        cmd.low   = va_r[29:0];
      end else if (level_r == ptw_pkg::LVL_L2 && big) begin
        busy_nxt  = 1'b0;
        level_nxt = ptw_pkg::LVL_L4;
        cmd.op    = ptw_pkg::OP_DONE_2M;
        cmd.base  = entry_data[ptw_pkg::ADDR_W-1:0];
        cmd.low   = {9'b0, va_r[20:0]};
      end else if (level_r == ptw_pkg::LVL_L1) begin
        busy_nxt  = 1'b0;
        level_nxt = ptw_pkg::LVL_L4;
        cmd.op    = ptw_pkg::OP_DONE_4K;
        cmd.base  = entry_data[ptw_pkg::ADDR_W-1:0];
        cmd.low   = {18'b0, va_r[11:0]};
      end else begin
        level_nxt = level_r + 1'b1;
        cmd.op    = ptw_pkg::OP_READ;
        cmd.base  = entry_data[ptw_pkg::ADDR_W-1:0];
        cmd.low   = {18'b0, next_slot, 3'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= ptw_pkg::LVL_L4;
      va_r    <= '0;
    end else begin
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
      va_r    <= va_nxt;
    end
  end

  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (level_r == ptw_pkg::LVL_L4))
    else $error("walk level left nonzero while idle");

endmodule

// File: rtl/ptw_back.sv
module ptw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptw_pkg::cmd_t               cmd,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output ptw_pkg::res_t               res,
  input  logic [ptw_pkg::PAB_W-1:0]   phys_addr_bits
);

  logic [ptw_pkg::PAB_W-1:0]  eff_bits;
  logic [ptw_pkg::ADDR_W-1:0] width_mask;
  logic [ptw_pkg::ADDR_W-1:0] low_mask;
  logic [ptw_pkg::ADDR_W-1:0] frame;
  logic                       adv;

  assign adv      = !cmd_empty && !res_full;
  assign cmd_pop  = adv;
  assign res_push = adv;

  // A width above the address width acts as the full width.
  assign eff_bits = (phys_addr_bits > ptw_pkg::PAB_MAX) ? ptw_pkg::PAB_MAX : phys_addr_bits;

  always_comb begin
    for (int i = 0; i < ptw_pkg::ADDR_W; i++) begin
      width_mask[i] = (ptw_pkg::PAB_W'(i) < eff_bits);
    end
  end

  always_comb begin
    unique case (cmd.op)
      ptw_pkg::OP_DONE_2M: low_mask = ptw_pkg::ADDR_W'(52'h1F_FFFF);
      ptw_pkg::OP_DONE_1G: low_mask = ptw_pkg::ADDR_W'(52'h3FFF_FFFF);
      default:             low_mask = ptw_pkg::ADDR_W'(52'hFFF);
    endcase
  end

  assign frame = cmd.base & width_mask & ~low_mask;

  always_comb begin
    res.address   = frame + {{(ptw_pkg::ADDR_W - ptw_pkg::LOW_W){1'b0}}, cmd.low};
    res.kind      = ptw_pkg::KIND_READ;
    res.page_size = ptw_pkg::PS_4K;
    unique case (cmd.op)
      ptw_pkg::OP_READ: begin
        res.kind = ptw_pkg::KIND_READ;
      end
      ptw_pkg::OP_DONE_4K: begin
        res.kind = ptw_pkg::KIND_DONE;
      end
      ptw_pkg::OP_DONE_2M: begin
        res.kind      = ptw_pkg::KIND_DONE;
        res.page_size = ptw_pkg::PS_2M;
      end
      ptw_pkg::OP_DONE_1G: begin
        res.kind      = ptw_pkg::KIND_DONE;
        res.page_size = ptw_pkg::PS_1G;
      end
      default: begin
        res.kind    = ptw_pkg::KIND_IGNORED;
        res.address = '0;
      end
    endcase
  end

  a_read_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cmd.op == ptw_pkg::OP_READ) |-> (res.address[2:0] == 3'b0))
    else $error("entry read address not 8-byte aligned");

endmodule

// File: rtl/four_level_page_table_walker.sv
// Flow: a word taken at the input is queued as a command, and the back writes its result
// to the result queue; while the result queue is full the command waits in its queue.
// Throughput: one word per cycle in steady state while neither queue is full, set by the
// combinational front update and the one-step masking adder in the back; two-entry queues decouple both sides.
// Reset: synchronous, active-low rst_n idles the walk, empties both queues and sets
// table_base to zero and phys_addr_bits to 36.
module four_level_page_table_walker #(
  parameter int CMD_DEPTH = ptw_pkg::CMD_DEPTH,
  parameter int OUT_DEPTH = ptw_pkg::OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_opcode,
  input  logic [ptw_pkg::VA_W-1:0]    in_virt_addr,
  input  logic [63:0]                 in_entry_data,
  // Result channel.
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [1:0]                  out_result_kind,
  output logic [ptw_pkg::ADDR_W-1:0]  out_address,
  output logic [1:0]                  out_page_size,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [ptw_pkg::ADDR_W-1:0]  cfg_data
);

  localparam int CMD_W = $bits(ptw_pkg::cmd_t);
  localparam int RES_W = $bits(ptw_pkg::res_t);

  // Configuration registers. Writes are always taken; the user must write only while idle (unchecked).
  logic [ptw_pkg::ADDR_W-1:0] table_base_r, table_base_nxt;
  logic [ptw_pkg::PAB_W-1:0]  phys_bits_r, phys_bits_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    table_base_nxt = table_base_r;
    phys_bits_nxt  = phys_bits_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ptw_pkg::REG_TABLE_BASE: table_base_nxt = cfg_data;
        ptw_pkg::REG_PHYS_BITS:  phys_bits_nxt  = cfg_data[ptw_pkg::PAB_W-1:0];
        default:                 table_base_nxt = table_base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r <= '0;
      phys_bits_r  <= ptw_pkg::PAB_RESET;
    end else begin
      table_base_r <= table_base_nxt;
      phys_bits_r  <= phys_bits_nxt;
    end
  end

  // The front takes each word, advances the walk state at once and queues a
  // command telling the back which base to mask and what low part to add.
  logic          in_accept;
  ptw_pkg::cmd_t front_cmd;
  ptw_pkg::cmd_t back_cmd;
  logic [CMD_W-1:0] back_cmd_bits;
  logic          cmd_empty;
  logic          cmd_pop;

  assign in_accept = in_push && !in_full;

  ptw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .opcode     (in_opcode),
    .virt_addr  (in_virt_addr),
    .entry_data (in_entry_data),
    .table_base (table_base_r),
    .cmd        (front_cmd)
  );

  ptw_fifo #(
    .DEPTH (CMD_DEPTH),
    .WIDTH (CMD_W)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .din   (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (back_cmd_bits),
    .empty (cmd_empty)
  );

  assign back_cmd = ptw_pkg::cmd_t'(back_cmd_bits);

  // The back applies the physical width mask and the frame alignment, adds the
  // slot offset or page offset, and writes the finished word to the result queue.
  ptw_pkg::res_t    back_res;
  ptw_pkg::res_t    out_res;
  logic [RES_W-1:0] out_res_bits;
  logic             res_push;
  logic             res_full;

  ptw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (back_cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (back_res),
    .phys_addr_bits (phys_bits_r)
  );

  ptw_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_res_bits),
    .empty (out_empty)
  );

  assign out_res         = ptw_pkg::res_t'(out_res_bits);
  assign out_result_kind = out_res.kind;
  assign out_address     = out_res.address;
  assign out_page_size   = out_res.page_size;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Tracks the walker's state and configuration and holds the words it must return, oldest first.
class walk_scoreboard;
  logic [ptw_pkg::ADDR_W-1:0] table_base;
  logic [ptw_pkg::PAB_W-1:0]  phys_bits;
  bit                         walking;
  logic [1:0]                 level;
  logic [ptw_pkg::VA_W-1:0]   held_va;
  ptw_pkg::res_t              walk_answers[$];
  int unsigned                errors;

  function new();
    table_base = '0;
    phys_bits  = ptw_pkg::PAB_RESET;
    walking    = 1'b0;
    level      = ptw_pkg::LVL_L4;
    held_va    = '0;
    errors     = 0;
  endfunction

  task report(string what);
    $display("tb_top: mismatch: %s", what);
    errors++;
  endtask

  function void set_reg(logic idx, logic [ptw_pkg::ADDR_W-1:0] data);
    if (idx == ptw_pkg::REG_TABLE_BASE) begin
      table_base = data;
    end else begin
      phys_bits = data[ptw_pkg::PAB_W-1:0];
    end
  endfunction

  // Widths past the architectural maximum saturate; small widths are taken literally.
  function logic [ptw_pkg::ADDR_W-1:0] phys_mask();
    int bits;
    bits = (phys_bits > ptw_pkg::PAB_MAX) ? ptw_pkg::ADDR_W : int'(phys_bits);
    return ptw_pkg::ADDR_W'((64'd1 << bits) - 64'd1);
  endfunction

  // Byte offset of the 8-byte entry that the held address selects at a level.
  function logic [ptw_pkg::ADDR_W-1:0] slot_offset(logic [1:0] lvl);
    logic [8:0] slot;
    slot = 9'(held_va >> (39 - 9 * int'(lvl)));
    return {40'd0, slot, 3'd0};
  endfunction

  function void note_word(logic opc, logic [ptw_pkg::VA_W-1:0] va, logic [63:0] entry);
    ptw_pkg::res_t               r;
    logic [ptw_pkg::ADDR_W-1:0]  mask;
    logic [ptw_pkg::ADDR_W-1:0]  masked;
    bit                          big;
    mask      = phys_mask();
    masked    = entry[ptw_pkg::ADDR_W-1:0] & mask;
    big       = entry[ptw_pkg::PAGE_SIZE_BIT];
    r.kind      = ptw_pkg::KIND_READ;
    r.address   = '0;
    r.page_size = ptw_pkg::PS_4K;
    if (opc == ptw_pkg::OPC_START) begin
      // A start always wins, even over a walk in progress.
      held_va   = va;
      walking   = 1'b1;
      level     = ptw_pkg::LVL_L4;
      r.address = (table_base & mask & ~52'hFFF) + slot_offset(ptw_pkg::LVL_L4);
    end else if (!walking) begin
      r.kind = ptw_pkg::KIND_IGNORED;
    end else if (level == ptw_pkg::LVL_L3 && big) begin
      r.kind      = ptw_pkg::KIND_DONE;
      r.address   = (masked & ~52'h3FFF_FFFF) + {22'd0, held_va[29:0]};
      r.page_size = ptw_pkg::PS_1G;
      walking     = 1'b0;
      level       = ptw_pkg::LVL_L4;
    end else if (level == ptw_pkg::LVL_L2 && big) begin
      r.kind      = ptw_pkg::KIND_DONE;
      r.address   = (masked & ~52'h1F_FFFF) + {31'd0, held_va[20:0]};
      r.page_size = ptw_pkg::PS_2M;
      walking     = 1'b0;
      level       = ptw_pkg::LVL_L4;
    end else if (level == ptw_pkg::LVL_L1) begin
      r.kind      = ptw_pkg::KIND_DONE;
      r.address   = (masked & ~52'hFFF) + {40'd0, held_va[11:0]};
      r.page_size = ptw_pkg::PS_4K;
      walking     = 1'b0;
      level       = ptw_pkg::LVL_L4;
    end else begin
      level     = level + 2'd1;
      r.address = (masked & ~52'hFFF) + slot_offset(level);
    end
    walk_answers.push_back(r);
  endfunction

  task check_word(logic [1:0] kind, logic [ptw_pkg::ADDR_W-1:0] addr, logic [1:0] ps);
    ptw_pkg::res_t want;
    if (walk_answers.size() == 0) begin
      report($sformatf("word with nothing pending: kind %0d address %h", kind, addr));
      return;
    end
    want = walk_answers.pop_front();
    if (kind !== want.kind)
      report($sformatf("result_kind %0d, wanted %0d", kind, want.kind));
    if (addr !== want.address)
      report($sformatf("address %h, wanted %h", addr, want.address));
    if (ps !== want.page_size)
      report($sformatf("page_size %0d, wanted %0d", ps, want.page_size));
  endtask
endclass

module tb_top;

  // Cycles with no handshake on any channel before the run is declared hung. The longest
  // legitimate quiet stretch is a long sender gap on top of a long receiver stall.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned WORDS_PER_PHASE = 100;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_push       = 1'b0;
  logic                          in_full;
  logic                          in_opcode     = ptw_pkg::OPC_START;
  logic [ptw_pkg::VA_W-1:0]      in_virt_addr  = '0;
  logic [63:0]                   in_entry_data = '0;
  logic                          out_empty;
  logic                          out_pop       = 1'b0;
  logic [1:0]                    out_result_kind;
  logic [ptw_pkg::ADDR_W-1:0]    out_address;
  logic [1:0]                    out_page_size;
  logic                          cfg_valid     = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_index     = ptw_pkg::REG_TABLE_BASE;
  logic [ptw_pkg::ADDR_W-1:0]    cfg_data      = '0;

  walk_scoreboard sb = new();

  // When calm is set neither side inserts gaps, giving back-to-back stretches.
  bit          calm = 1'b0;
  int unsigned pop_hold = 0;
  int unsigned quiet_cycles = 0;

  four_level_page_table_walker u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_virt_addr    (in_virt_addr),
    .in_entry_data   (in_entry_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result_kind (out_result_kind),
    .out_address     (out_address),
    .out_page_size   (out_page_size),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  // Gap lengths: mostly none or a short pause, now and then a long pause.
  function automatic int unsigned gap_len();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ptw_pkg::VA_W-1:0] rand_va();
    return ptw_pkg::VA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ptw_pkg::ADDR_W-1:0] rand_addr();
    return ptw_pkg::ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] rand_entry();
    return {$urandom, $urandom};
  endfunction

  // Result side. Outputs are sampled at the clock edge, before the block's own updates land,
  // so the word checked here is the one that was accepted at this edge. After each accepted
  // word the receiver may hold pop low for a random stretch.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        sb.check_word(out_result_kind, out_address, out_page_size);
        pop_hold = gap_len();
      end else if (pop_hold != 0) begin
        pop_hold--;
      end
      out_pop <= (pop_hold == 0);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Presents one word and returns at the edge where it is taken. push is left high so that
  // the next word can follow without a bubble; a gap lowers it first.
  task automatic send_word(logic opc, logic [ptw_pkg::VA_W-1:0] va, logic [63:0] entry);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_opcode     <= opc;
    in_virt_addr  <= va;
    in_entry_data <= entry;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_word(opc, va, entry);
  endtask

  // Every word produces exactly one result, so once nothing is pending both queues are empty
  // and the registers may be rewritten.
  task automatic drain();
    in_push <= 1'b0;
    while (sb.walk_answers.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back; valid stays high across the pair.
  task automatic configure(logic [ptw_pkg::ADDR_W-1:0] base,
                           logic [ptw_pkg::ADDR_W-1:0] bits_word);
    logic                         idx;
    logic [ptw_pkg::ADDR_W-1:0]   data;
    cfg_valid <= 1'b1;
    for (int r = 0; r < 2; r++) begin
      idx  = (r == 0) ? ptw_pkg::REG_TABLE_BASE : ptw_pkg::REG_PHYS_BITS;
      data = (r == 0) ? base : bits_word;
      cfg_index <= idx;
      cfg_data  <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete walks with random content, where the size bit at the two middle levels
  // decides how deep the walk goes. Some walks are cut short, which leaves the next start
  // to hit a busy walker or a stray entry to be taken as the next level. The rest is noise:
  // lone starts and entries that arrive with no walk open. Those stray entries do not count
  // toward the budget; the walker discards those that meet no open walk.
  task automatic random_walks(int unsigned budget);
    int unsigned sent;
    logic [63:0] entry;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 82) begin
        send_word(ptw_pkg::OPC_START, rand_va(), rand_entry());
        sent++;
        for (int lvl = 0; lvl < 4; lvl++) begin
          if ($urandom_range(0, 19) == 0) break;
          entry = rand_entry();
          if (lvl == 1 || lvl == 2) begin
            entry[ptw_pkg::PAGE_SIZE_BIT] = ($urandom_range(0, 9) < 3);
          end
          send_word(ptw_pkg::OPC_ENTRY, rand_va(), entry);
          sent++;
          if ((lvl == 1 || lvl == 2) && entry[ptw_pkg::PAGE_SIZE_BIT]) break;
        end
      end else if ($urandom_range(0, 1) == 0) begin
        send_word(ptw_pkg::OPC_START, rand_va(), rand_entry());
        sent++;
      end else begin
        send_word(ptw_pkg::OPC_ENTRY, rand_va(), rand_entry());
      end
    end
  endtask

  initial begin
    logic [ptw_pkg::ADDR_W-1:0] junk;
    logic [63:0]                no_big;

    no_big = ~64'h80;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset configuration. A 1 GiB walk with zero and all-ones
    // entries, then an entry with no walk open.
    send_word(ptw_pkg::OPC_START, '0, '0);
    send_word(ptw_pkg::OPC_ENTRY, '0, '0);
    send_word(ptw_pkg::OPC_ENTRY, '0, '1);
    send_word(ptw_pkg::OPC_ENTRY, '1, '1);
    // A 2 MiB walk from the top of the address space; the size bit in the level-4 entry
    // must not stop the walk.
    send_word(ptw_pkg::OPC_START, '1, '0);
    send_word(ptw_pkg::OPC_ENTRY, '1, '1);
    send_word(ptw_pkg::OPC_ENTRY, '0, no_big);
    send_word(ptw_pkg::OPC_ENTRY, '0, '1);
    // A full 4 KiB walk; the size bit at the last level means nothing.
    send_word(ptw_pkg::OPC_START, rand_va(), '1);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), no_big);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), '0);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), rand_entry() & no_big);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), '1);
    // A walk restarted while busy, then carried to the end, then one more stray entry.
    send_word(ptw_pkg::OPC_START, rand_va(), '0);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), rand_entry());
    send_word(ptw_pkg::OPC_START, rand_va(), '0);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), rand_entry());
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), rand_entry() & no_big);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), rand_entry() & no_big);
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), rand_entry());
    send_word(ptw_pkg::OPC_ENTRY, rand_va(), '0);
    drain();

    // Random phases, each under its own configuration: widest mask with an all-ones base,
    // a zero width that masks everything away, a width code far past the maximum, the
    // narrowest architectural width, a random code and the reset width. Unused data bits
    // of the width register carry random junk where it does not matter.
    for (int p = 0; p < 6; p++) begin
      junk = rand_addr();
      case (p)
        0: configure({ptw_pkg::ADDR_W{1'b1}}, ptw_pkg::ADDR_W'(ptw_pkg::PAB_MAX));
        1: configure(rand_addr(), '0);
        2: configure(rand_addr(), {junk[ptw_pkg::ADDR_W-1:ptw_pkg::PAB_W], 6'd63});
        3: configure('0, ptw_pkg::ADDR_W'(32));
        4: configure(rand_addr(),
                     {junk[ptw_pkg::ADDR_W-1:ptw_pkg::PAB_W], 6'($urandom_range(0, 63))});
        default: configure(rand_addr(), ptw_pkg::ADDR_W'(ptw_pkg::PAB_RESET));
      endcase
      calm = (p == 3) || ($urandom_range(0, 3) == 0);
      random_walks(WORDS_PER_PHASE);
      drain();
    end

    // Results pass through both queues to come out; wait long enough for any extra word to show.
    calm = 1'b1;
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: four_level_page_table_walker.f
rtl/ptw_pkg.sv
rtl/ptw_fifo.sv
rtl/ptw_front.sv
rtl/ptw_back.sv
rtl/four_level_page_table_walker.sv
verif/tb_top.sv
